FILE: rtl/core/gdc_pkg.sv
package gdc_pkg;

  typedef enum logic {
    OP_DMY = 1'b0,
    OP_ORD = 1'b1
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [4:0]  day_in;
    logic [3:0]  month_in;
    logic [13:0] year_in;
    logic [8:0]  ordinal_in;
  } in_t;

  typedef struct packed {
    logic        valid_res;
    logic [4:0]  cur_day;
    logic [3:0]  cur_month;
    logic [13:0] cur_year;
    logic [4:0]  next_day_of_month;
    logic [3:0]  next_month;
    logic [13:0] next_year;
    logic [4:0]  prev_day_of_month;
    logic [3:0]  prev_month;
    logic [13:0] prev_year;
    logic [8:0]  day_of_year;
    logic [21:0] serial_day;
  } out_t;

  localparam logic [13:0] MaxYear       = 14'd9999;
  localparam logic [3:0]  MonthsPerYear = 4'd12;
  localparam logic [8:0]  DaysPerYear   = 9'd365;
  localparam logic [12:0] Recip100      = 13'd5243;
  localparam int          Recip100Shift = 19;
  localparam logic [6:0]  Hundred       = 7'd100;

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = leap ? 5'd29 : 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

  function automatic logic [8:0] cum_days(input logic [3:0] m, input logic leap);
    logic [8:0] n;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    if (leap && m > 4'd2) begin
      n = n + 9'd1;
    end
    return n;
  endfunction

endpackage

FILE: rtl/core/gregorian_date_calculator_core.sv
// Proleptic Gregorian date calculator. Each transfer carries a date as day, month and year
// (op = OP_DMY) or as year and day-of-year (op = OP_ORD); the result gives the resolved date,
// the next and previous dates, the day-of-year and the serial day (1/1/1 is day 1). An input
// that names no real date yields valid_res = 0 and all other fields zero. The block takes one
// item per cycle when out_stall_i does not hold it back: an input register feeds a single
// stage of combinational date logic that loads the result register, and a result held by
// out_stall_i still lets one more input enter the input register.
module gregorian_date_calculator_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  gdc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output gdc_pkg::out_t out_data_o
);
  import gdc_pkg::*;

  logic        in_valid_q;
  in_t         in_q;
  logic        out_valid_q;
  out_t        out_q;
  out_t        res;
  logic        adv;
  logic        in_load;

  logic [13:0] yr;
  logic [13:0] yp;
  logic [26:0] y_prod;
  logic [6:0]  y_cent;
  logic [13:0] y_rem;
  logic        leap;
  logic [8:0]  ylen;
  logic [3:0]  mon;
  logic [4:0]  dd;
  logic [8:0]  doy;
  logic [8:0]  tmp_doy;
  logic        ok;
  logic [4:0]  dim;
  logic [3:0]  pm;
  logic [26:0] yp_prod;
  logic [6:0]  yp_cent;
  logic [22:0] serial;

  assign adv     = !out_valid_q || !out_stall_i;
  assign in_load = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_load) begin
        in_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (adv && in_valid_q) begin
      out_q <= res;
    end
  end

  always_comb begin
    res    = '0;
    yr     = in_q.year_in;
    yp     = yr - 14'd1;
    y_prod = 27'(yr) * 27'(Recip100);
    y_cent = 7'(y_prod >> Recip100Shift);
    y_rem  = yr - 14'(y_cent) * 14'(Hundred);
    leap   = (yr[1:0] == 2'd0 && y_rem != 14'd0) || (y_rem == 14'd0 && y_cent[1:0] == 2'd0);
    ylen   = leap ? DaysPerYear + 9'd1 : DaysPerYear;

    mon     = in_q.month_in;
    dd      = in_q.day_in;
    doy     = 9'd0;
    tmp_doy = 9'd0;
    ok      = 1'b0;
    if (in_q.op == OP_DMY) begin
      ok  = mon >= 4'd1 && mon <= MonthsPerYear && dd >= 5'd1 && dd <= month_days(mon, leap);
      doy = cum_days(mon, leap) + 9'(dd);
    end else begin
      ok  = in_q.ordinal_in >= 9'd1 && in_q.ordinal_in <= ylen;
      doy = in_q.ordinal_in;
      mon = 4'd1;
      for (int k = 2; k <= 12; k++) begin
        if (in_q.ordinal_in > cum_days(4'(k), leap)) begin
          mon = 4'(k);
        end
      end
      tmp_doy = in_q.ordinal_in - cum_days(mon, leap);
      dd      = tmp_doy[4:0];
    end
    ok = ok && yr != 14'd0 && yr <= MaxYear;

    dim     = month_days(mon, leap);
    yp_prod = 27'(yp) * 27'(Recip100);
    yp_cent = 7'(yp_prod >> Recip100Shift);
    serial  = 23'(yp) * 23'(DaysPerYear) + 23'(yp >> 2) - 23'(yp_cent) + 23'(yp_cent >> 2)
              + 23'(doy);

    pm = (mon > 4'd1) ? mon - 4'd1 : MonthsPerYear;

    if (ok) begin
      res.valid_res   = 1'b1;
      res.cur_day     = dd;
      res.cur_month   = mon;
      res.cur_year    = yr;
      res.day_of_year = doy;
      res.serial_day  = serial[21:0];

      if (dd >= dim) begin
        res.next_day_of_month = 5'd1;
        if (mon >= MonthsPerYear) begin
          res.next_month = 4'd1;
          res.next_year  = yr + 14'd1;
        end else begin
          res.next_month = mon + 4'd1;
          res.next_year  = yr;
        end
      end else begin
        res.next_day_of_month = dd + 5'd1;
        res.next_month        = mon;
        res.next_year         = yr;
      end

      if (dd == 5'd1 && mon == 4'd1 && yr == 14'd1) begin
        res.prev_day_of_month = dd;
        res.prev_month        = mon;
        res.prev_year         = yr;
      end else if (dd > 5'd1) begin
        res.prev_day_of_month = dd - 5'd1;
        res.prev_month        = mon;
        res.prev_year         = yr;
      end else begin
        res.prev_day_of_month = month_days(pm, leap);
        res.prev_month        = pm;
        res.prev_year         = (mon > 4'd1) ? yr : yr - 14'd1;
      end
    end
  end

  assign in_stall_o  = in_valid_q && !adv;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q)
    else $error("input stalled with a free slot");

  a_hold_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && in_stall_o |=> in_valid_q && $stable(in_q))
    else $error("input register changed while stalled");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.valid_res |-> out_data_o.serial_day == 22'd0 &&
      out_data_o.cur_year == 14'd0 && out_data_o.day_of_year == 9'd0)
    else $error("invalid result carries data");

  a_valid_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.valid_res |-> out_data_o.serial_day != 22'd0 &&
      out_data_o.day_of_year != 9'd0 && out_data_o.cur_day != 5'd0 &&
      out_data_o.cur_month != 4'd0)
    else $error("valid result with empty date");

  a_next_year: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.valid_res |->
      (out_data_o.next_year == out_data_o.cur_year ||
       out_data_o.next_year == out_data_o.cur_year + 14'd1))
    else $error("next date skips a year");

endmodule
